// ----- rtl/mts_pkg.sv -----
// ----------------------------------------------------------------------------
// mts_pkg
// Types, tune tables and the control store of the melody tone sequencer.
// ----------------------------------------------------------------------------
package mts_pkg;

   localparam int unsigned NOTE_COUNT_DEFAULT     = 28;
   localparam int unsigned TIMER_CLOCK_HZ_DEFAULT = 1000000;

   typedef struct packed {
      logic        action;
      logic [31:0] now_ms;
   } req_type;

   typedef struct packed {
      logic        playing;
      logic        tone_on;
      logic [15:0] period_reload;
      logic [14:0] duty_compare;
      logic        note_changed;
      logic [7:0]  note_position;
   } rsp_type;

   localparam logic ACTION_PLAY = 1'b0;
   localparam logic ACTION_STOP = 1'b1;

   // Control word: datapath operation, jump condition and jump target.
   localparam int unsigned PC_W = 3;

   localparam logic [2:0] OP_NOP     = 3'd0;
   localparam logic [2:0] OP_ACCEPT  = 3'd1;
   localparam logic [2:0] OP_UPDATE  = 3'd2;
   localparam logic [2:0] OP_DIVSTEP = 3'd3;
   localparam logic [2:0] OP_TONE    = 3'd4;
   localparam logic [2:0] OP_EMIT    = 3'd5;

   localparam logic [2:0] COND_NEVER    = 3'd0;
   localparam logic [2:0] COND_ALWAYS   = 3'd1;
   localparam logic [2:0] COND_NO_ITEM  = 3'd2;
   localparam logic [2:0] COND_NO_DIV   = 3'd3;
   localparam logic [2:0] COND_DIV_MORE = 3'd4;
   localparam logic [2:0] COND_OUT_BUSY = 3'd5;

   localparam logic [PC_W-1:0] PC_START = 3'd0;
   localparam logic [PC_W-1:0] PC_UPD   = 3'd1;
   localparam logic [PC_W-1:0] PC_DIV   = 3'd2;
   localparam logic [PC_W-1:0] PC_TONE  = 3'd3;
   localparam logic [PC_W-1:0] PC_EMIT  = 3'd4;
   localparam logic [PC_W-1:0] PC_LAST  = 3'd5;

   typedef struct packed {
      logic [2:0]      op;
      logic [2:0]      cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   // The program: wait for an item, update the melody state, run the period
   // divider when a new tone starts, set the tone, hand over the result.
   function automatic ucode_type ucode(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         PC_START: w = '{OP_ACCEPT,  COND_NO_ITEM,  PC_START};
         PC_UPD:   w = '{OP_UPDATE,  COND_NO_DIV,   PC_EMIT};
         PC_DIV:   w = '{OP_DIVSTEP, COND_DIV_MORE, PC_DIV};
         PC_TONE:  w = '{OP_TONE,    COND_NEVER,    PC_START};
         PC_EMIT:  w = '{OP_EMIT,    COND_OUT_BUSY, PC_EMIT};
         PC_LAST:  w = '{OP_NOP,     COND_ALWAYS,   PC_START};
         default:  w = '{OP_NOP,     COND_ALWAYS,   PC_START};
      endcase
      return w;
   endfunction

   // Tune in Hz; entries past the tune are silent.
   function automatic logic [15:0] tune_freq(input logic [7:0] i);
      logic [15:0] f;
      case (i)
         8'd0:  f = 16'd660;   8'd1:  f = 16'd660;   8'd2:  f = 16'd0;
         8'd3:  f = 16'd660;   8'd4:  f = 16'd0;     8'd5:  f = 16'd520;
         8'd6:  f = 16'd660;   8'd7:  f = 16'd0;     8'd8:  f = 16'd770;
         8'd9:  f = 16'd0;     8'd10: f = 16'd770;   8'd11: f = 16'd800;
         8'd12: f = 16'd840;   8'd13: f = 16'd880;   8'd14: f = 16'd0;
         8'd15: f = 16'd1046;  8'd16: f = 16'd988;   8'd17: f = 16'd880;
         8'd18: f = 16'd784;   8'd19: f = 16'd660;   8'd20: f = 16'd0;
         8'd21: f = 16'd660;   8'd22: f = 16'd780;   8'd23: f = 16'd660;
         8'd24: f = 16'd880;   8'd25: f = 16'd0;     8'd26: f = 16'd1046;
         8'd27: f = 16'd0;
         default: f = 16'd0;
      endcase
      return f;
   endfunction

   // Note lengths in ms; entries past the tune end at once.
   function automatic logic [15:0] tune_dur(input logic [7:0] i);
      logic [15:0] d;
      case (i)
         8'd0:  d = 16'd150;  8'd1:  d = 16'd150;  8'd2:  d = 16'd100;
         8'd3:  d = 16'd150;  8'd4:  d = 16'd100;  8'd5:  d = 16'd150;
         8'd6:  d = 16'd150;  8'd7:  d = 16'd100;  8'd8:  d = 16'd150;
         8'd9:  d = 16'd100;  8'd10: d = 16'd150;  8'd11: d = 16'd150;
         8'd12: d = 16'd200;  8'd13: d = 16'd250;  8'd14: d = 16'd100;
         8'd15: d = 16'd300;  8'd16: d = 16'd150;  8'd17: d = 16'd150;
         8'd18: d = 16'd150;  8'd19: d = 16'd200;  8'd20: d = 16'd150;
         8'd21: d = 16'd150;  8'd22: d = 16'd150;  8'd23: d = 16'd150;
         8'd24: d = 16'd200;  8'd25: d = 16'd100;  8'd26: d = 16'd300;
         8'd27: d = 16'd300;
         default: d = 16'd0;
      endcase
      return d;
   endfunction

endpackage

// ----- rtl/melody_tone_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// melody_tone_sequencer_unit
// Steps through a fixed tune on millisecond polls and produces timer
// reload and compare values for a 50 percent duty tone.
// ----------------------------------------------------------------------------
//  channel   direction  payload   handshake
//  req_      in         req_type  req_valid / req_stall
//  rsp_      out        rsp_type  rsp_valid / rsp_stall
//
// A small control store sequences each item: accept, update, then, for an item
// that starts a tone, the one-bit-a-step restoring divider over DW, the bit width
// of TIMER_CLOCK_HZ, and the tone step, and last the emit step and an idle step.
// Reset is synchronous and active high and clears the melody state. A stalled
// result sits in the output register while the next item is taken; the
// sequencer waits only when a second result is ready.
// ----------------------------------------------------------------------------
module melody_tone_sequencer_unit #(
   parameter int unsigned NOTE_COUNT     = mts_pkg::NOTE_COUNT_DEFAULT,
   parameter int unsigned TIMER_CLOCK_HZ = mts_pkg::TIMER_CLOCK_HZ_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mts_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mts_pkg::rsp_type rsp_payload
);
   import mts_pkg::*;

   localparam int unsigned DW = $clog2(TIMER_CLOCK_HZ + 1);
   localparam int unsigned CW = $clog2(DW);
   localparam logic [DW-1:0] CLK_BITS = DW'(TIMER_CLOCK_HZ);
   localparam logic [8:0]    NOTE_END = 9'(NOTE_COUNT);

   logic [PC_W-1:0] pc_ff, pc_in;
   req_type         req_ff, req_in;
   logic [7:0]      idx_ff, idx_in;
   logic [31:0]     start_ff, start_in;
   logic            play_ff, play_in;
   logic            tone_en_ff, tone_en_in;
   logic [15:0]     reload_ff, reload_in;
   logic [14:0]     compare_ff, compare_in;
   logic            changed_ff, changed_in;
   logic [15:0]     freq_ff, freq_in;
   logic [15:0]     rem_ff, rem_in;
   logic [DW-1:0]   quot_ff, quot_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_ff, rsp_in;

   ucode_type   cw;
   logic        accept;
   logic        out_free;
   logic        skip_div;
   logic        cond_true;
   logic [31:0] elapsed;
   logic [8:0]  next_idx;
   logic [15:0] next_freq;
   logic [16:0] rem_sh;
   logic        div_ge;
   logic [31:0] q_ext;
   logic [31:0] reload_full;

   assign cw        = ucode(pc_ff);
   assign req_stall = (cw.op != OP_ACCEPT);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign elapsed   = req_ff.now_ms - start_ff;
   assign next_idx  = {1'b0, idx_ff} + 9'd1;
   assign next_freq = tune_freq(next_idx[7:0]);

   assign rem_sh = {rem_ff, CLK_BITS[cnt_ff]};
   assign div_ge = (rem_sh >= {1'b0, freq_ff});

   assign q_ext       = 32'(quot_ff);
   assign reload_full = (q_ext == 32'd0) ? 32'd0 : q_ext - 32'd1;

   always_comb begin
      req_in       = req_ff;
      idx_in       = idx_ff;
      start_in     = start_ff;
      play_in      = play_ff;
      tone_en_in   = tone_en_ff;
      reload_in    = reload_ff;
      compare_in   = compare_ff;
      changed_in   = changed_ff;
      freq_in      = freq_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      skip_div     = 1'b1;

      case (cw.op)
         OP_ACCEPT: begin
            if (accept) begin
               req_in = req_payload;
            end
         end
         OP_UPDATE: begin
            changed_in = 1'b0;
            rem_in     = '0;
            quot_in    = '0;
            cnt_in     = CW'(DW - 1);
            freq_in    = next_freq;
            if (req_ff.action == ACTION_STOP) begin
               play_in    = 1'b0;
               tone_en_in = 1'b0;
               idx_in     = '0;
               start_in   = '0;
               changed_in = 1'b1;
            end else begin
               play_in = 1'b1;
               if (elapsed >= {16'd0, tune_dur(idx_ff)}) begin
                  start_in   = req_ff.now_ms;
                  changed_in = 1'b1;
                  if (next_idx >= NOTE_END) begin
                     idx_in     = '0;
                     tone_en_in = 1'b0;
                  end else begin
                     idx_in = next_idx[7:0];
                     if (next_freq == 16'd0) begin
                        tone_en_in = 1'b0;
                     end else begin
                        skip_div = 1'b0;
                     end
                  end
               end
            end
         end
         OP_DIVSTEP: begin
            rem_in  = div_ge ? 16'(rem_sh - {1'b0, freq_ff}) : rem_sh[15:0];
            quot_in = {quot_ff[DW-2:0], div_ge};
            cnt_in  = cnt_ff - CW'(1);
         end
         OP_TONE: begin
            reload_in  = (reload_full > 32'd65535) ? 16'hFFFF : reload_full[15:0];
            compare_in = (reload_full > 32'd65535) ? 15'h7FFF : reload_full[15:1];
            tone_en_in = 1'b1;
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_in.playing        = play_ff;
               rsp_in.tone_on        = tone_en_ff;
               rsp_in.period_reload  = tone_en_ff ? reload_ff : 16'd0;
               rsp_in.duty_compare   = tone_en_ff ? compare_ff : 15'd0;
               rsp_in.note_changed   = changed_ff;
               rsp_in.note_position  = idx_ff;
            end
         end
         default: begin
         end
      endcase

      case (cw.cond)
         COND_NEVER:    cond_true = 1'b0;
         COND_ALWAYS:   cond_true = 1'b1;
         COND_NO_ITEM:  cond_true = !req_valid;
         COND_NO_DIV:   cond_true = skip_div;
         COND_DIV_MORE: cond_true = (cnt_ff != '0);
         COND_OUT_BUSY: cond_true = !out_free;
         default:       cond_true = 1'b1;
      endcase

      pc_in = cond_true ? cw.target : pc_ff + PC_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= PC_START;
         idx_ff       <= '0;
         start_ff     <= '0;
         play_ff      <= 1'b0;
         tone_en_ff   <= 1'b0;
         reload_ff    <= '0;
         compare_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         idx_ff       <= idx_in;
         start_ff     <= start_in;
         play_ff      <= play_in;
         tone_en_ff   <= tone_en_in;
         reload_ff    <= reload_in;
         compare_ff   <= compare_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff     <= req_in;
      changed_ff <= changed_in;
      freq_ff    <= freq_in;
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      cnt_ff     <= cnt_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // An accepted item always moves on to the update step.
   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      accept |=> pc_ff == PC_UPD)
      else $error("accepted item did not reach the update step");

   // The program counter never leaves the control store.
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= PC_LAST)
      else $error("program counter outside control store");

   // A sounding tone always has a compare of half the reload.
   a_half_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.tone_on |->
         rsp_payload.duty_compare == rsp_payload.period_reload[15:1])
      else $error("compare is not half of reload");

   // A stopped melody is silent and parked on the first note.
   a_stop_silent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.playing |->
         !rsp_payload.tone_on && rsp_payload.note_position == 8'd0)
      else $error("stopped melody not silent at note zero");

endmodule
